// ----- src/tmts_pkg.sv -----
// package for the trajectory meeting time solver: payload types and sizing constants
`timescale 1ns / 1ps
`default_nettype none
package tmts_pkg;
	localparam int unsigned WORD_W = 32;

	typedef struct packed {
		logic signed [WORD_W-1:0] start_time_one;
		logic signed [WORD_W-1:0] position_one;
		logic signed [WORD_W-1:0] velocity_one;
		logic signed [WORD_W-1:0] accel_one;
		logic signed [WORD_W-1:0] start_time_two;
		logic signed [WORD_W-1:0] position_two;
		logic signed [WORD_W-1:0] velocity_two;
		logic signed [WORD_W-1:0] accel_two;
	} tmts_in_t;

	typedef struct packed {
		logic                     found;
		logic signed [WORD_W-1:0] first_time;
		logic signed [WORD_W-1:0] second_time;
		logic                     saturated;
	} tmts_out_t;

	// meaning of one item once the coefficients are known
	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_LINEAR = 2'd1,
		KIND_QUAD   = 2'd2
	} kind_t;
endpackage
`default_nettype wire

// ----- src/trajectory_meeting_time_solver.sv -----
// trajectory meeting time solver: coefficient, square root and divider pipeline
`timescale 1ns / 1ps
`default_nettype none
// Pipelined solver for the meeting times of two constant-acceleration trajectories.
// One trajectory pair enters per cycle while stall is low; each transaction yields
// exactly one result after 8 coefficient stages (products split into
// 32x32 pieces), 72 square root stages (one result bit each, over a 144-bit
// discriminant), 1 divider set-up stage, 35 divider stages (one stage that decides
// saturation from the high quotient bits, then one quotient bit per stage for the
// two roots in parallel, QB = 34) and the output register. Latency is set by the
// bit-serial square root and restoring dividers; throughput is one transaction per
// clock while not stalled. A stall freezes the whole pipeline, and the output
// register holds its result until taken.
module trajectory_meeting_time_solver #(
	parameter int FRAC_BITS = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire tmts_pkg::tmts_in_t  in_data,
	output logic                     out_valid,
	input  wire                      out_stall,
	output tmts_pkg::tmts_out_t      out_data
);
	import tmts_pkg::*;

	localparam int W     = 192;
	localparam int BQW   = 64;          // magnitude width of bq
	localparam int CW    = 96;          // magnitude width of c2
	localparam int SQ_N  = 72;          // root bits of a value below 2^144
	localparam int QB    = 34;          // quotient bits; larger is saturated
	localparam int NW    = 144;         // magnitude width of numerators
	localparam int DW    = 112;         // magnitude width of divisors
	localparam int DPS   = QB + 1;      // divider stage count
	localparam int DEPTH = 8 + SQ_N + DPS + 2;

	typedef logic signed [W-1:0] wide_t;

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// valid bits of all stages
	logic [DEPTH-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	function automatic wide_t sx(input logic signed [WORD_W-1:0] v);
		return wide_t'(v);
	endfunction

	// stage 1: differences and first products (32x32)
	wide_t p_s1, dv_s1, dx_s1;
	logic signed [2*WORD_W-1:0] a1t1_s1, a2t2_s1, v1t1_s1, v2t2_s1;
	logic signed [WORD_W-1:0] t1_s1, t2_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1    <= sx(in_data.accel_one) - sx(in_data.accel_two);
			dv_s1   <= sx(in_data.velocity_one) - sx(in_data.velocity_two);
			dx_s1   <= sx(in_data.position_one) - sx(in_data.position_two);
			a1t1_s1 <= $signed(in_data.accel_one) * $signed(in_data.start_time_one);
			a2t2_s1 <= $signed(in_data.accel_two) * $signed(in_data.start_time_two);
			v1t1_s1 <= $signed(in_data.velocity_one) * $signed(in_data.start_time_one);
			v2t2_s1 <= $signed(in_data.velocity_two) * $signed(in_data.start_time_two);
			t1_s1   <= in_data.start_time_one;
			t2_s1   <= in_data.start_time_two;
		end
	end

	// stage 2: bq, c2 shifts and a*t*t as high and low half products
	wide_t p_s2, bq_s2, c2a_s2, c2b_s2;
	logic signed [2*WORD_W-1:0] a1h_s2, a2h_s2;
	logic signed [2*WORD_W:0]   a1l_s2, a2l_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2   <= p_s1;
			bq_s2  <= (dv_s1 <<< FRAC_BITS) - wide_t'(a1t1_s1) + wide_t'(a2t2_s1);
			c2a_s2 <= dx_s1 <<< (2*FRAC_BITS + 1);
			c2b_s2 <= (wide_t'(v1t1_s1) - wide_t'(v2t2_s1)) <<< (FRAC_BITS + 1);
			a1h_s2 <= $signed(a1t1_s1[2*WORD_W-1:WORD_W]) * t1_s1;
			a2h_s2 <= $signed(a2t2_s1[2*WORD_W-1:WORD_W]) * t2_s1;
			a1l_s2 <= $signed({1'b0, a1t1_s1[WORD_W-1:0]}) * t1_s1;
			a2l_s2 <= $signed({1'b0, a2t2_s1[WORD_W-1:0]}) * t2_s1;
		end
	end

	// stage 3: recombine half products, magnitudes of bq and p
	wide_t p_s3, bq_s3, c2ab_s3, a1tt_s3, a2tt_s3;
	logic [BQW-1:0]    abq_s3;
	logic [WORD_W-1:0] ap_s3;
	logic              pneg_s3;
	wide_t abq_w, ap_w;
	assign abq_w = bq_s2[W-1] ? -bq_s2 : bq_s2;
	assign ap_w  = p_s2[W-1] ? -p_s2 : p_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3    <= p_s2;
			bq_s3   <= bq_s2;
			c2ab_s3 <= c2a_s2 - c2b_s2;
			a1tt_s3 <= (wide_t'(a1h_s2) <<< WORD_W) + wide_t'(a1l_s2);
			a2tt_s3 <= (wide_t'(a2h_s2) <<< WORD_W) + wide_t'(a2l_s2);
			abq_s3  <= abq_w[BQW-1:0];
			ap_s3   <= ap_w[WORD_W-1:0];
			pneg_s3 <= p_s2[W-1];
		end
	end

	// stage 4: c2 and partial products of bq squared
	wide_t p_s4, bq_s4, c2_s4;
	logic [WORD_W-1:0]   ap_s4;
	logic                pneg_s4;
	logic [2*WORD_W-1:0] bll_s4, bhl_s4, bhh_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s4    <= p_s3;
			bq_s4   <= bq_s3;
			c2_s4   <= c2ab_s3 + a1tt_s3 - a2tt_s3;
			ap_s4   <= ap_s3;
			pneg_s4 <= pneg_s3;
			bll_s4  <= abq_s3[WORD_W-1:0] * abq_s3[WORD_W-1:0];
			bhl_s4  <= abq_s3[BQW-1:WORD_W] * abq_s3[WORD_W-1:0];
			bhh_s4  <= abq_s3[BQW-1:WORD_W] * abq_s3[BQW-1:WORD_W];
		end
	end

	// stage 5: bq squared, magnitude and sign of p*c2
	wide_t p_s5, bq_s5, c2_s5, bb_s5;
	logic [WORD_W-1:0] ap_s5;
	logic [CW-1:0]     ac2_s5;
	logic              pcneg_s5;
	wide_t ac2_w;
	assign ac2_w = c2_s4[W-1] ? -c2_s4 : c2_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s5     <= p_s4;
			bq_s5    <= bq_s4;
			c2_s5    <= c2_s4;
			bb_s5    <= (wide_t'(bhh_s4) << (2*WORD_W)) + (wide_t'(bhl_s4) << (WORD_W + 1))
			            + wide_t'(bll_s4);
			ap_s5    <= ap_s4;
			ac2_s5   <= ac2_w[CW-1:0];
			pcneg_s5 <= pneg_s4 ^ c2_s4[W-1];
		end
	end

	// stage 6: partial products of p*c2
	wide_t p_s6, bq_s6, c2_s6, bb_s6;
	logic                pcneg_s6;
	logic [2*WORD_W-1:0] pc0_s6, pc1_s6, pc2_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s6     <= p_s5;
			bq_s6    <= bq_s5;
			c2_s6    <= c2_s5;
			bb_s6    <= bb_s5;
			pcneg_s6 <= pcneg_s5;
			pc0_s6   <= ap_s5 * ac2_s5[WORD_W-1:0];
			pc1_s6   <= ap_s5 * ac2_s5[2*WORD_W-1:WORD_W];
			pc2_s6   <= ap_s5 * ac2_s5[CW-1:2*WORD_W];
		end
	end

	// stage 7: magnitude of p*c2
	wide_t p_s7, bq_s7, c2_s7, bb_s7, pcm_s7;
	logic pcneg_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s7     <= p_s6;
			bq_s7    <= bq_s6;
			c2_s7    <= c2_s6;
			bb_s7    <= bb_s6;
			pcneg_s7 <= pcneg_s6;
			pcm_s7   <= (wide_t'(pc2_s6) << (2*WORD_W)) + (wide_t'(pc1_s6) << WORD_W)
			            + wide_t'(pc0_s6);
		end
	end

	// stage 8: discriminant and case selection
	wide_t p_s8, bq_s8, c2_s8, d_s8;
	kind_t kind_s8;
	wide_t d_w;
	assign d_w = pcneg_s7 ? bb_s7 + pcm_s7 : bb_s7 - pcm_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s8  <= p_s7;
			bq_s8 <= bq_s7;
			c2_s8 <= c2_s7;
			d_s8  <= d_w;
			priority if (p_s7 == '0 && bq_s7 != '0) kind_s8 <= KIND_LINEAR;
			else if (p_s7 != '0 && !d_w[W-1] && d_w != '0) kind_s8 <= KIND_QUAD;
			else kind_s8 <= KIND_NONE;
		end
	end

	// square root stages, one result bit per stage
	typedef struct packed {
		logic [2*SQ_N-1:0] rem;
		logic [SQ_N-1:0]   root;
		logic [2*SQ_N-1:0] src;
		logic [W-1:0]      p;
		logic [W-1:0]      bq;
		logic [W-1:0]      c2;
		kind_t             kind;
	} sq_t;
	sq_t sq_q [SQ_N+1];

	always_comb begin
		sq_q[0].rem  = '0;
		sq_q[0].root = '0;
		sq_q[0].src  = (kind_s8 == KIND_QUAD) ? d_s8[2*SQ_N-1:0] : '0;
		sq_q[0].p    = p_s8;
		sq_q[0].bq   = bq_s8;
		sq_q[0].c2   = c2_s8;
		sq_q[0].kind = kind_s8;
	end

	for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
		logic [2*SQ_N+1:0] trial, rem_n;
		logic [2*SQ_N+1:0] sub;
		always_comb begin
			rem_n = {sq_q[g].rem, sq_q[g].src[2*SQ_N-1 -: 2]};
			sub   = {sq_q[g].root, 2'b01};
			trial = rem_n - sub;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_q[g+1].src  <= sq_q[g].src << 2;
				sq_q[g+1].p    <= sq_q[g].p;
				sq_q[g+1].bq   <= sq_q[g].bq;
				sq_q[g+1].c2   <= sq_q[g].c2;
				sq_q[g+1].kind <= sq_q[g].kind;
				if (!trial[2*SQ_N+1]) begin
					sq_q[g+1].rem  <= trial[2*SQ_N-1:0];
					sq_q[g+1].root <= {sq_q[g].root[SQ_N-2:0], 1'b1};
				end else begin
					sq_q[g+1].rem  <= rem_n[2*SQ_N-1:0];
					sq_q[g+1].root <= {sq_q[g].root[SQ_N-2:0], 1'b0};
				end
			end
		end
	end

	// numerators and divisor, signed
	wide_t n1_w, n2_w, den_w, root_w;
	assign root_w = wide_t'({1'b0, sq_q[SQ_N].root});
	always_comb begin
		if (sq_q[SQ_N].kind == KIND_LINEAR) begin
			n1_w  = -sq_q[SQ_N].c2;
			n2_w  = -sq_q[SQ_N].c2;
			den_w = sq_q[SQ_N].bq <<< 1;
		end else begin
			n1_w  = -sq_q[SQ_N].bq - root_w;
			n2_w  = -sq_q[SQ_N].bq + root_w;
			den_w = (sq_q[SQ_N].kind == KIND_QUAD) ? sq_q[SQ_N].p : wide_t'(1);
		end
	end

	// divider preparation: magnitudes, signs, overflow of high quotient bits
	typedef struct packed {
		logic [NW-1:0] num1, num2;
		logic [DW-1:0] den;
		logic          neg1, neg2;
		logic [QB-1:0] q1, q2;
		logic [NW-1:0] r1, r2;
		logic          big1, big2;
		kind_t         kind;
	} dv_t;
	dv_t dv_q [DPS+1];

	wide_t a1_w, a2_w, ad_w;
	assign a1_w = n1_w[W-1] ? -n1_w : n1_w;
	assign a2_w = n2_w[W-1] ? -n2_w : n2_w;
	assign ad_w = den_w[W-1] ? -den_w : den_w;

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_q[0].num1 <= a1_w[NW-1:0];
			dv_q[0].num2 <= a2_w[NW-1:0];
			dv_q[0].den  <= ad_w[DW-1:0];
			dv_q[0].neg1 <= n1_w[W-1] ^ den_w[W-1];
			dv_q[0].neg2 <= n2_w[W-1] ^ den_w[W-1];
			dv_q[0].q1   <= '0;
			dv_q[0].q2   <= '0;
			dv_q[0].r1   <= '0;
			dv_q[0].r2   <= '0;
			dv_q[0].big1 <= 1'b0;
			dv_q[0].big2 <= 1'b0;
			dv_q[0].kind <= sq_q[SQ_N].kind;
		end
	end

	// first divider stage: quotient bits above QB decide saturation outright
	logic [NW-1:0] hi1_w, hi2_w;
	dv_t dv1_w;
	assign hi1_w = dv_q[0].num1 >> QB;
	assign hi2_w = dv_q[0].num2 >> QB;
	always_comb begin
		dv1_w      = dv_q[0];
		dv1_w.big1 = hi1_w >= NW'(dv_q[0].den);
		dv1_w.big2 = hi2_w >= NW'(dv_q[0].den);
		dv1_w.r1   = hi1_w;
		dv1_w.r2   = hi2_w;
		dv1_w.num1 = dv_q[0].num1 << (NW - QB);
		dv1_w.num2 = dv_q[0].num2 << (NW - QB);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			dv_q[1] <= dv1_w;
		end
	end

	// restoring division, one quotient bit per stage for both roots
	for (genvar g = 1; g < DPS; g++) begin : g_div
		logic [NW:0] t1, t2;
		dv_t nxt;
		always_comb begin
			t1 = {dv_q[g].r1, dv_q[g].num1[NW-1]} - (NW+1)'(dv_q[g].den);
			t2 = {dv_q[g].r2, dv_q[g].num2[NW-1]} - (NW+1)'(dv_q[g].den);
			nxt      = dv_q[g];
			nxt.num1 = dv_q[g].num1 << 1;
			nxt.num2 = dv_q[g].num2 << 1;
			nxt.q1   = {dv_q[g].q1[QB-2:0], !t1[NW]};
			nxt.q2   = {dv_q[g].q2[QB-2:0], !t2[NW]};
			nxt.r1   = t1[NW] ? {dv_q[g].r1[NW-2:0], dv_q[g].num1[NW-1]} : t1[NW-1:0];
			nxt.r2   = t2[NW] ? {dv_q[g].r2[NW-2:0], dv_q[g].num2[NW-1]} : t2[NW-1:0];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_q[g+1] <= nxt;
			end
		end
	end

	// sign and saturation into the output register
	function automatic logic [WORD_W:0] sat_q(input logic [QB-1:0] q, input logic big,
		input logic neg);
		logic [QB-1:0] lim;
		lim = neg ? QB'(34'h080000000) : QB'(34'h07FFFFFFF);
		if (big || q > lim) return {1'b1, lim[WORD_W-1:0]};
		return {1'b0, neg ? WORD_W'(-q[WORD_W-1:0]) : q[WORD_W-1:0]};
	endfunction

	logic [WORD_W:0] f1_w, f2_w;
	assign f1_w = sat_q(dv_q[DPS].q1, dv_q[DPS].big1, dv_q[DPS].neg1);
	assign f2_w = sat_q(dv_q[DPS].q2, dv_q[DPS].big2, dv_q[DPS].neg2);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (dv_q[DPS].kind == KIND_NONE) begin
				out_data <= '0;
			end else begin
				out_data.found       <= 1'b1;
				out_data.first_time  <= f1_w[WORD_W-1:0];
				out_data.second_time <= f2_w[WORD_W-1:0];
				out_data.saturated   <= f1_w[WORD_W] | f2_w[WORD_W];
			end
		end
	end
	assign out_valid = vld_q[DEPTH-1];

	// checks
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> !out_data.saturated && out_data.first_time == '0)
		else $error("no-solution result carries data");
endmodule
`default_nettype wire
